@@ hw/rtl/http_request_header_parser_macros.svh @@
// Assertion macros for the request header parser.
`ifndef HTTP_REQUEST_HEADER_PARSER_MACROS_SVH
`define HTTP_REQUEST_HEADER_PARSER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define HRHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define HRHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/hrhp_pkg.sv @@
// ----------------------------------------------------------------------------
// hrhp_pkg
// Types, character codes and match tables for the request header parser.
// ----------------------------------------------------------------------------
package hrhp_pkg;

  typedef enum logic [5:0] {
    PH_LINE  = 6'b000001,
    PH_NAME  = 6'b000010,
    PH_VALUE = 6'b000100,
    PH_BODY  = 6'b001000,
    PH_DONE  = 6'b010000,
    PH_ERROR = 6'b100000
  } phase_e;

  typedef enum logic [3:0] {
    DIG_NONE  = 4'b0001,
    DIG_RUN   = 4'b0010,
    DIG_TRAIL = 4'b0100,
    DIG_BAD   = 4'b1000
  } digit_e;

  localparam logic [2:0] ROLE_DELIM  = 3'd0;
  localparam logic [2:0] ROLE_METHOD = 3'd1;
  localparam logic [2:0] ROLE_REST   = 3'd2;
  localparam logic [2:0] ROLE_NAME   = 3'd3;
  localparam logic [2:0] ROLE_VALUE  = 3'd4;
  localparam logic [2:0] ROLE_BODY   = 3'd5;
  localparam logic [2:0] ROLE_IGNORE = 3'd6;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [2:0] METHOD_LEN = 3'd4;
  localparam logic [3:0] NAME_LEN   = 4'd14;

  typedef struct packed {
    phase_e     phase;
    logic       cr_seen;
    logic       line_start;
    logic       lead_done;
    logic       pend_sp;
    logic       inner_sp;
    logic [2:0] mpos;
    logic       mmatch;
    logic [3:0] npos;
    logic       nmatch;
    digit_e     digits;
    logic       err;
  } ctl_t;

  localparam ctl_t CTL_RESET = '{
    phase:      PH_LINE,
    cr_seen:    1'b0,
    line_start: 1'b1,
    lead_done:  1'b0,
    pend_sp:    1'b0,
    inner_sp:   1'b0,
    mpos:       3'd0,
    mmatch:     1'b1,
    npos:       4'd0,
    nmatch:     1'b1,
    digits:     DIG_NONE,
    err:        1'b0
  };

  typedef struct packed {
    ctl_t       ctl;
    logic [2:0] role;
    logic       fend;
  } feed_t;

  typedef struct packed {
    logic [7:0]  echo;
    logic [2:0]  role;
    logic        fend;
    logic        hdone;
    logic        rdone;
    logic        post;
    logic [31:0] clen;
    logic        err;
  } result_t;

  function automatic logic [7:0] post_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = 8'h50;
      2'd1:    ch = 8'h4F;
      2'd2:    ch = 8'h53;
      default: ch = 8'h54;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] clen_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h43;
      4'd1:    ch = 8'h6F;
      4'd2:    ch = 8'h6E;
      4'd3:    ch = 8'h74;
      4'd4:    ch = 8'h65;
      4'd5:    ch = 8'h6E;
      4'd6:    ch = 8'h74;
      4'd7:    ch = 8'h2D;
      4'd8:    ch = 8'h4C;
      4'd9:    ch = 8'h65;
      4'd10:   ch = 8'h6E;
      4'd11:   ch = 8'h67;
      4'd12:   ch = 8'h74;
      4'd13:   ch = 8'h68;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic post_now(input ctl_t s);
    return !s.err && s.mmatch && (s.mpos == METHOD_LEN) && (s.pend_sp || s.inner_sp);
  endfunction

endpackage

@@ hw/rtl/hrhp_core.sv @@
// ----------------------------------------------------------------------------
// hrhp_core
// Parser state and the per-word update: line framing, method and name
// matching, decimal length parse and body count.
// ----------------------------------------------------------------------------
module hrhp_core import hrhp_pkg::*; #(
  parameter int LENGTH_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic [7:0] byte_i,
  output result_t    res_o
);

  localparam int LB = LENGTH_BITS;

  ctl_t          ctl_q, ctl_d;
  logic [LB-1:0] acc_q, acc_d;
  logic [LB-1:0] lv_q, lv_d;
  logic [LB-1:0] bc_q, bc_d;

  function automatic feed_t feed(input ctl_t si, input logic [LB-1:0] ai,
                                 input logic [7:0] c, output logic [LB-1:0] ao);
    feed_t         f;
    logic          ws;
    logic          dig;
    logic [LB+3:0] prod;
    f.ctl  = si;
    f.role = ROLE_DELIM;
    f.fend = 1'b0;
    ao     = ai;
    ws     = c inside {CH_SP, CH_TAB};
    dig    = c inside {[CH_ZERO:CH_NINE]};
    prod   = ({4'b0, ai} << 3) + ({4'b0, ai} << 1) + {{LB{1'b0}}, c[3:0]};
    case (si.phase)
      PH_LINE: begin
        if (!si.lead_done || (!si.pend_sp && !si.inner_sp)) begin
          if (ws) begin
            if (si.lead_done) begin
              f.ctl.pend_sp = 1'b1;
              f.fend        = 1'b1;
            end
          end else begin
            f.ctl.lead_done = 1'b1;
            if ((si.mpos >= METHOD_LEN) || (post_char(si.mpos[1:0]) != c)) begin
              f.ctl.mmatch = 1'b0;
            end
            if (si.mpos != 3'd7) begin
              f.ctl.mpos = si.mpos + 3'd1;
            end
            f.role = ROLE_METHOD;
          end
        end else if (!ws) begin
          f.ctl.inner_sp = 1'b1;
          f.role         = ROLE_REST;
        end
      end
      PH_NAME: begin
        f.ctl.line_start = 1'b0;
        if (c == CH_COLON) begin
          f.ctl.phase  = PH_VALUE;
          f.ctl.digits = DIG_NONE;
          ao           = '0;
          f.fend       = 1'b1;
        end else begin
          if ((si.npos >= NAME_LEN) || (clen_char(si.npos) != c)) begin
            f.ctl.nmatch = 1'b0;
          end
          if (si.npos != 4'd15) begin
            f.ctl.npos = si.npos + 4'd1;
          end
          f.role = ROLE_NAME;
        end
      end
      default: begin
        f.role = ROLE_VALUE;
        case (si.digits)
          DIG_NONE: begin
            if (dig) begin
              f.ctl.digits = DIG_RUN;
              ao           = LB'(c[3:0]);
            end else if (!ws) begin
              f.ctl.digits = DIG_BAD;
            end
          end
          DIG_RUN: begin
            if (dig) begin
              ao = (prod[LB+3:LB] != 4'd0) ? {LB{1'b1}} : prod[LB-1:0];
            end else if (ws) begin
              f.ctl.digits = DIG_TRAIL;
            end else begin
              f.ctl.digits = DIG_BAD;
            end
          end
          DIG_TRAIL: begin
            if (!ws) begin
              f.ctl.digits = DIG_BAD;
            end
          end
          default: ;
        endcase
      end
    endcase
    return f;
  endfunction

  feed_t         f_cr, f_by;
  logic [LB-1:0] acc_cr, acc_by;
  logic [LB:0]   bc_inc;

  always_comb begin
    f_cr   = feed(ctl_q, acc_q, CH_CR, acc_cr);
    f_by   = feed(ctl_q.cr_seen ? f_cr.ctl : ctl_q, ctl_q.cr_seen ? acc_cr : acc_q,
                  byte_i, acc_by);
    bc_inc = {1'b0, bc_q} + {{LB{1'b0}}, 1'b1};

    ctl_d       = ctl_q;
    acc_d       = acc_q;
    lv_d        = lv_q;
    bc_d        = bc_q;
    res_o       = '0;
    res_o.echo  = byte_i;
    res_o.role  = ROLE_DELIM;

    case (ctl_q.phase)
      PH_LINE, PH_NAME, PH_VALUE: begin
        if (byte_i == CH_CR) begin
          if (ctl_q.cr_seen) begin
            ctl_d = f_cr.ctl;
            acc_d = acc_cr;
          end
          ctl_d.cr_seen = 1'b1;
        end else if ((byte_i == CH_LF) && ctl_q.cr_seen) begin
          ctl_d.cr_seen = 1'b0;
          case (ctl_q.phase)
            PH_LINE: begin
              if (ctl_q.lead_done && !ctl_q.pend_sp && !ctl_q.inner_sp) begin
                res_o.fend = 1'b1;
              end
              if (!ctl_q.inner_sp) begin
                ctl_d.err   = 1'b1;
                ctl_d.phase = PH_ERROR;
              end else begin
                ctl_d.phase      = PH_NAME;
                ctl_d.npos       = '0;
                ctl_d.nmatch     = 1'b1;
                ctl_d.line_start = 1'b1;
                ctl_d.digits     = DIG_NONE;
                acc_d            = '0;
              end
            end
            PH_NAME: begin
              if (ctl_q.line_start) begin
                res_o.hdone = 1'b1;
                bc_d        = '0;
                ctl_d.phase = (post_now(ctl_q) && (lv_q != '0)) ? PH_BODY : PH_DONE;
              end else begin
                ctl_d.npos       = '0;
                ctl_d.nmatch     = 1'b1;
                ctl_d.line_start = 1'b1;
                ctl_d.digits     = DIG_NONE;
                acc_d            = '0;
              end
            end
            default: begin
              if (ctl_q.nmatch && (ctl_q.npos == NAME_LEN)) begin
                lv_d = (ctl_q.digits inside {DIG_RUN, DIG_TRAIL}) ? acc_q : '0;
              end
              res_o.fend       = 1'b1;
              ctl_d.phase      = PH_NAME;
              ctl_d.npos       = '0;
              ctl_d.nmatch     = 1'b1;
              ctl_d.line_start = 1'b1;
              ctl_d.digits     = DIG_NONE;
              acc_d            = '0;
            end
          endcase
        end else begin
          ctl_d         = f_by.ctl;
          acc_d         = acc_by;
          ctl_d.cr_seen = 1'b0;
          res_o.role    = f_by.role;
          res_o.fend    = f_by.fend;
        end
      end
      PH_BODY: begin
        res_o.role = ROLE_BODY;
        bc_d       = bc_inc[LB-1:0];
        if (bc_inc >= {1'b0, lv_q}) begin
          res_o.fend  = 1'b1;
          ctl_d.phase = PH_DONE;
        end
      end
      default: begin
        res_o.role = ROLE_IGNORE;
      end
    endcase

    res_o.rdone = (ctl_d.phase == PH_DONE);
    res_o.post  = post_now(ctl_d);
    res_o.clen  = 32'(lv_d);
    res_o.err   = ctl_d.err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= CTL_RESET;
      acc_q <= '0;
      lv_q  <= '0;
      bc_q  <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_d;
      acc_q <= acc_d;
      lv_q  <= lv_d;
      bc_q  <= bc_d;
    end
  end

endmodule

@@ hw/rtl/http_request_header_parser.sv @@
// ----------------------------------------------------------------------------
// http_request_header_parser
// Byte-wide HTTP request parser: tags each word and reports header status.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one request byte per word.
// Output channel: out_valid_o / out_stall_i carry one result word per input
// word: the byte echoed, its role, field end, headers done, request done,
// POST flag, parsed Content-Length and parse error.
// A word passes an input register and then a result register; out_valid_o
// rises when the result register takes it. One word is taken every cycle
// while the receiver does not stall, as set by the combinational parser
// update between them (state compare plus a shift-add by ten on the length).
// While the receiver stalls, the result register holds and the input
// register still takes one more word; in_stall_o rises once both are full.
// Reset clears both registers' valid flags and returns the parser to the
// start of a request line; after a completed request or a parse error every
// byte is tagged ignored until the next reset.
// ----------------------------------------------------------------------------
`include "http_request_header_parser_macros.svh"

module http_request_header_parser import hrhp_pkg::*; #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  byte_echo_o,
  output logic [2:0]  byte_role_o,
  output logic        field_end_o,
  output logic        headers_done_o,
  output logic        request_done_o,
  output logic        is_post_o,
  output logic [31:0] content_length_o,
  output logic        parse_error_o
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q;
  result_t    res_q, res;
  logic       out_free, move;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign move       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;

  hrhp_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (move),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_vld_q <= 1'b1;
      end else if (move) begin
        in_vld_q <= 1'b0;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= data_byte_i;
    end
    if (move) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign byte_echo_o      = res_q.echo;
  assign byte_role_o      = res_q.role;
  assign field_end_o      = res_q.fend;
  assign headers_done_o   = res_q.hdone;
  assign request_done_o   = res_q.rdone;
  assign is_post_o        = res_q.post;
  assign content_length_o = res_q.clen;
  assign parse_error_o    = res_q.err;

  `HRHP_ASSERT(a_done_err_excl, !(out_valid_o && request_done_o && parse_error_o), "done, error")
  `HRHP_ASSERT(a_hdone_delim, !(out_valid_o && headers_done_o) || byte_role_o == ROLE_DELIM, "hdone")
  `HRHP_ASSERT(a_post_no_err, !(out_valid_o && is_post_o && parse_error_o), "post with error")
  `HRHP_ASSERT_NEXT(a_stall_hold, in_stall_o, out_valid_o && in_vld_q, "stall lost word")

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the byte-wide HTTP request header parser.
// One request is streamed after a single reset: a short table of request-line
// and header bytes, then generated header lines (exact, broken and near-miss
// Content-Length headers, lines with no colon, stray CRs, raw noise), a final
// Content-Length and blank line, the POST body and a tail of ignored bytes.
// Every result word is compared field by field with a software parser kept in
// step with accepted input words (typed table rows against their row), under
// phases of sender and receiver idling, one long receiver hold and one drain pause.
// ----------------------------------------------------------------------------
module tb import hrhp_pkg::*;;

  localparam int          DIR_N      = 25;
  localparam int          HDR_BYTES  = 1080;
  localparam int          HOLD_AT    = 700;
  localparam int          HOLD_LEN   = 60;
  localparam int          PAUSE_AT   = 1200;
  localparam int          LIMIT      = 300000;
  localparam longint unsigned LEN_MAX = 64'h0000_0000_FFFF_FFFF;
  localparam logic [31:0]  POST_WORD = "POST";
  localparam logic [111:0] CLEN_WORD = "Content-Length";

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    result_t    res;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  byte_echo_o;
  logic [2:0]  byte_role_o;
  logic        field_end_o;
  logic        headers_done_o;
  logic        request_done_o;
  logic        is_post_o;
  logic [31:0] content_length_o;
  logic        parse_error_o;

  http_request_header_parser DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .byte_echo_o      (byte_echo_o),
    .byte_role_o      (byte_role_o),
    .field_end_o      (field_end_o),
    .headers_done_o   (headers_done_o),
    .request_done_o   (request_done_o),
    .is_post_o        (is_post_o),
    .content_length_o (content_length_o),
    .parse_error_o    (parse_error_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  dir_row_t   dir_tab [DIR_N];
  logic [7:0] stim_q [$];
  result_t    want_q [$];
  int         n_taken   = 0;
  int         n_results = 0;
  int         errors    = 0;
  int         cycles    = 0;
  int         n_hdr     = 0;
  int         body_len  = 0;

  // software copy of the parser state
  phase_e          pr_phase      = PH_LINE;
  logic            pr_cr         = 1'b0;
  logic            pr_line_start = 1'b1;
  logic            pr_lead_done  = 1'b0;
  logic            pr_gap        = 1'b0;
  logic            pr_rest       = 1'b0;
  logic [2:0]      pr_mpos       = 3'd0;
  logic            pr_mok        = 1'b1;
  logic [3:0]      pr_npos       = 4'd0;
  logic            pr_nok        = 1'b1;
  digit_e          pr_digits     = DIG_NONE;
  longint unsigned pr_acc        = 0;
  longint unsigned pr_clen       = 0;
  longint unsigned pr_body       = 0;
  logic            pr_err        = 1'b0;

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SP || c == CH_TAB;
  endfunction

  function automatic logic post_seen();
    return !pr_err && pr_mok && pr_mpos == METHOD_LEN && (pr_gap || pr_rest);
  endfunction

  function automatic void new_header_line();
    pr_npos       = 4'd0;
    pr_nok        = 1'b1;
    pr_line_start = 1'b1;
    pr_digits     = DIG_NONE;
    pr_acc        = 0;
  endfunction

  function automatic void scan_char(input logic [7:0] c, output logic [2:0] role,
                                    output logic fend);
    longint unsigned d;
    int k;
    role = ROLE_DELIM;
    fend = 1'b0;
    d    = 64'(c[3:0]);
    case (pr_phase)
      PH_LINE: begin
        if (!pr_lead_done || (!pr_gap && !pr_rest)) begin
          if (is_blank(c)) begin
            if (pr_lead_done) begin
              pr_gap = 1'b1;
              fend   = 1'b1;
            end
          end else begin
            pr_lead_done = 1'b1;
            if (pr_mpos >= METHOD_LEN || POST_WORD[8*(3-pr_mpos[1:0]) +: 8] != c)
              pr_mok = 1'b0;
            if (pr_mpos < 3'd7) pr_mpos++;
            role = ROLE_METHOD;
          end
        end else if (!is_blank(c)) begin
          pr_rest = 1'b1;
          role    = ROLE_REST;
        end
      end
      PH_NAME: begin
        pr_line_start = 1'b0;
        if (c == CH_COLON) begin
          pr_phase  = PH_VALUE;
          pr_digits = DIG_NONE;
          pr_acc    = 0;
          fend      = 1'b1;
        end else begin
          k = (pr_npos < NAME_LEN) ? int'(pr_npos) : 0;
          if (pr_npos >= NAME_LEN || CLEN_WORD[8*(13-k) +: 8] != c) pr_nok = 1'b0;
          if (pr_npos < 4'd15) pr_npos++;
          role = ROLE_NAME;
        end
      end
      default: begin
        role = ROLE_VALUE;
        case (pr_digits)
          DIG_NONE: begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
              pr_digits = DIG_RUN;
              pr_acc    = d;
            end else if (!is_blank(c)) pr_digits = DIG_BAD;
          end
          DIG_RUN: begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
              if (pr_acc > (LEN_MAX - d) / 10) pr_acc = LEN_MAX;
              else pr_acc = pr_acc * 10 + d;
            end else if (is_blank(c)) pr_digits = DIG_TRAIL;
            else pr_digits = DIG_BAD;
          end
          DIG_TRAIL: begin
            if (!is_blank(c)) pr_digits = DIG_BAD;
          end
          default: ;
        endcase
      end
    endcase
  endfunction

  function automatic result_t parse_byte(input logic [7:0] c);
    logic [2:0] role, spare_role;
    logic       fend, hd, spare_fend;
    result_t    r;
    role = ROLE_DELIM;
    fend = 1'b0;
    hd   = 1'b0;
    if (pr_phase == PH_LINE || pr_phase == PH_NAME || pr_phase == PH_VALUE) begin
      if (c == CH_CR) begin
        if (pr_cr) scan_char(CH_CR, spare_role, spare_fend);
        pr_cr = 1'b1;
      end else if (c == CH_LF && pr_cr) begin
        pr_cr = 1'b0;
        case (pr_phase)
          PH_LINE: begin
            if (pr_lead_done && !pr_gap && !pr_rest) fend = 1'b1;
            if (!pr_rest) begin
              pr_err   = 1'b1;
              pr_phase = PH_ERROR;
            end else begin
              pr_phase = PH_NAME;
              new_header_line();
            end
          end
          PH_NAME: begin
            if (pr_line_start) begin
              hd      = 1'b1;
              pr_body = 0;
              if (post_seen() && pr_clen != 0) pr_phase = PH_BODY;
              else pr_phase = PH_DONE;
            end else new_header_line();
          end
          default: begin
            if (pr_nok && pr_npos == NAME_LEN)
              pr_clen = (pr_digits == DIG_RUN || pr_digits == DIG_TRAIL) ? pr_acc : 0;
            fend     = 1'b1;
            pr_phase = PH_NAME;
            new_header_line();
          end
        endcase
      end else begin
        // a CR not followed by LF counts as content
        if (pr_cr) scan_char(CH_CR, spare_role, spare_fend);
        pr_cr = 1'b0;
        scan_char(c, role, fend);
      end
    end else if (pr_phase == PH_BODY) begin
      role = ROLE_BODY;
      pr_body++;
      if (pr_body >= pr_clen) begin
        fend     = 1'b1;
        pr_phase = PH_DONE;
      end
    end else begin
      role = ROLE_IGNORE;
    end
    r.echo  = c;
    r.role  = role;
    r.fend  = fend;
    r.hdone = hd;
    r.rdone = pr_phase == PH_DONE;
    r.post  = post_seen();
    r.clen  = pr_clen[31:0];
    r.err   = pr_err;
    return r;
  endfunction

  function automatic dir_row_t row(input logic [7:0] b, input logic typed,
                                   input logic [2:0] role, input logic fend,
                                   input logic post);
    dir_row_t t;
    t.b         = b;
    t.typed     = typed;
    t.res       = '0;
    t.res.echo  = b;
    t.res.role  = role;
    t.res.fend  = fend;
    t.res.post  = post;
    return t;
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) stim_q.push_back(s[i]);
  endfunction

  function automatic void put_noise(input bit no_colon);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (no_colon && b == CH_COLON) b = 8'hBA;
    // never let noise close a line
    if (b == CH_LF && stim_q.size() > 0 && stim_q[$] == CH_CR) b = 8'h8A;
    stim_q.push_back(b);
  endfunction

  function automatic void put_digits(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = CH_ZERO + 8'($urandom_range(0, 9));
      stim_q.push_back(b);
    end
  endfunction

  function automatic void put_ws();
    int n;
    n = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) stim_q.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
  endfunction

  function automatic int idle_pct(input int n, input bit rx);
    int mode;
    mode = (n / 200) % 4;
    if (mode == 3) return 23;
    if ((mode == 1 && !rx) || (mode == 2 && rx)) return 48;
    return 0;
  endfunction

  task automatic check_field(input string nm, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", nm, want, got);
      errors++;
    end
  endtask

  // result check first, then prediction for the word taken at this edge
  always @(posedge clk_i) begin : scoreboard
    result_t got, want;
    if (out_valid_o && !out_stall_i) begin
      got = '{echo: byte_echo_o, role: byte_role_o, fend: field_end_o,
              hdone: headers_done_o, rdone: request_done_o, post: is_post_o,
              clen: content_length_o, err: parse_error_o};
      if (want_q.size() == 0) begin
        $error("result word with nothing expected: echo %0h", byte_echo_o);
        errors++;
      end else begin
        want = want_q.pop_front();
        check_field("byte_echo", 32'(want.echo), 32'(got.echo));
        check_field("byte_role", 32'(want.role), 32'(got.role));
        check_field("field_end", 32'(want.fend), 32'(got.fend));
        check_field("headers_done", 32'(want.hdone), 32'(got.hdone));
        check_field("request_done", 32'(want.rdone), 32'(got.rdone));
        check_field("is_post", 32'(want.post), 32'(got.post));
        check_field("content_length", want.clen, got.clen);
        check_field("parse_error", 32'(want.err), 32'(got.err));
      end
      n_results <= n_results + 1;
    end
    if (in_valid_i && !in_stall_o) begin
      want = parse_byte(data_byte_i);
      if (n_taken < DIR_N && dir_tab[n_taken].typed) want = dir_tab[n_taken].res;
      want_q.push_back(want);
      n_taken <= n_taken + 1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("[http_request_header_parser] ERROR");
      $finish;
    end
  end

  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && n_taken >= HOLD_AT) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        for (int k = 0; k < HOLD_LEN; k++) @(posedge clk_i);
      end else begin
        out_stall_i <= $urandom_range(0, 99) < idle_pct(n_taken, 1'b1);
      end
    end
  end

  initial begin : stimulus
    int send_idx, kind, j, n;
    logic [7:0] b;
    send_idx = 0;

    dir_tab = '{
      row(8'h20, 1, ROLE_DELIM, 0, 0), row(CH_TAB, 1, ROLE_DELIM, 0, 0),
      row("P", 1, ROLE_METHOD, 0, 0),  row("O", 0, ROLE_DELIM, 0, 0),
      row("S", 0, ROLE_DELIM, 0, 0),   row("T", 0, ROLE_DELIM, 0, 0),
      row(CH_SP, 1, ROLE_DELIM, 1, 1), row(CH_TAB, 0, ROLE_DELIM, 0, 0),
      row("/", 0, ROLE_DELIM, 0, 0),   row(CH_CR, 0, ROLE_DELIM, 0, 0),
      row(8'hFF, 1, ROLE_REST, 0, 1),  row(8'h00, 1, ROLE_REST, 0, 1),
      row(CH_CR, 0, ROLE_DELIM, 0, 0), row(CH_LF, 0, ROLE_DELIM, 0, 0),
      row("A", 0, ROLE_DELIM, 0, 0),   row(CH_CR, 0, ROLE_DELIM, 0, 0),
      row(CH_LF, 0, ROLE_DELIM, 0, 0), row(CH_COLON, 1, ROLE_DELIM, 1, 1),
      row(CH_SP, 0, ROLE_DELIM, 0, 0), row("7", 0, ROLE_DELIM, 0, 0),
      row(CH_CR, 0, ROLE_DELIM, 0, 0), row(CH_LF, 0, ROLE_DELIM, 0, 0),
      row(CH_CR, 0, ROLE_DELIM, 0, 0), row(CH_CR, 0, ROLE_DELIM, 0, 0),
      row(CH_LF, 0, ROLE_DELIM, 0, 0)
    };
    foreach (dir_tab[i]) stim_q.push_back(dir_tab[i].b);

    while (stim_q.size() < HDR_BYTES) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: begin
          put_text("Content-Length:");
          put_ws();
          if ($urandom_range(0, 5) == 0)
            put_text($urandom_range(0, 1) ? "4294967295" : "4294967296");
          else put_digits($urandom_range(1, 12));
          put_ws();
        end
        3: begin
          put_text("Content-Length:");
          put_ws();
          case ($urandom_range(0, 3))
            0: ;
            1: begin
              put_digits($urandom_range(1, 4));
              put_noise(0);
            end
            2: begin
              put_digits(2);
              put_text(" ");
              put_digits(2);
            end
            default: begin
              put_noise(0);
              put_digits(3);
            end
          endcase
        end
        4: begin
          j = $urandom_range(0, 2);
          n = (j == 1) ? $urandom_range(1, 13) : 14;
          for (int i = 0; i < n; i++) begin
            b = CLEN_WORD[8*(13-i) +: 8];
            if (j == 0 && i == 7) b = 8'($urandom_range(0, 255));
            stim_q.push_back(b);
          end
          if (j == 2) put_text("s");
          put_text(": ");
          put_digits($urandom_range(1, 5));
        end
        5: begin
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++) put_noise(0);
          stim_q.push_back(CH_COLON);
          n = $urandom_range(0, 10);
          for (int i = 0; i < n; i++) put_noise(0);
        end
        6: begin
          n = $urandom_range(1, 10);
          for (int i = 0; i < n; i++) put_noise(1);
        end
        7: begin
          put_text("Content-Length");
          case ($urandom_range(0, 2))
            0: begin
              put_text(": 1");
              stim_q.push_back(CH_CR);
              put_text("2");
            end
            1: begin
              stim_q.push_back(CH_CR);
              put_text(": 5");
            end
            default: begin
              put_text(": 12 ");
              stim_q.push_back(CH_CR);
            end
          endcase
        end
        8: begin
          stim_q.push_back(CH_COLON);
          put_digits($urandom_range(1, 4));
        end
        default: begin
          n = $urandom_range(1, 16);
          for (int i = 0; i < n; i++) put_noise(0);
        end
      endcase
      stim_q.push_back(CH_CR);
      stim_q.push_back(CH_LF);
      n_hdr++;
    end

    // last Content-Length wins, then the blank line and the body
    body_len = $urandom_range(550, 700);
    put_text($sformatf("Content-Length: %0d", body_len));
    stim_q.push_back(CH_CR);
    stim_q.push_back(CH_LF);
    stim_q.push_back(CH_CR);
    stim_q.push_back(CH_LF);
    for (int i = 0; i < body_len + 20; i++) stim_q.push_back(8'($urandom_range(0, 255)));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (send_idx < stim_q.size()) begin
      @(posedge clk_i);
      if (in_valid_i && in_stall_o) continue;
      if (send_idx == PAUSE_AT && n_results != send_idx) in_valid_i <= 1'b0;
      else if ($urandom_range(0, 99) < idle_pct(n_taken, 1'b0)) in_valid_i <= 1'b0;
      else begin
        in_valid_i  <= 1'b1;
        data_byte_i <= stim_q[send_idx];
        send_idx++;
      end
    end
    do @(posedge clk_i); while (in_valid_i && in_stall_o);
    in_valid_i <= 1'b0;

    while (n_results != stim_q.size()) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    if (want_q.size() != 0) begin
      $error("%0d expected result words never arrived", want_q.size());
      errors++;
    end

    $display("Request of %0d words: %0d table rows, %0d header lines, %0d-byte POST body",
             stim_q.size(), DIR_N, n_hdr, body_len);
    $display("%0d result words checked over four idling phases, a hold and a drain",
             n_results);
    if (errors == 0) begin
      $display("[http_request_header_parser] OK");
    end else begin
      $display("[http_request_header_parser] ERROR");
    end
    $finish;
  end

endmodule
